@@ sv/bfpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg: shared definitions for the best-fit pool allocator
// Function and status codes, field widths, register map and parameter defaults.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    // default sizing of the pool and the block table
    localparam int DEF_POOL_BYTES  = 1048576;
    localparam int DEF_MAX_BLOCKS  = 256;
    localparam int DEF_ALIGN_BYTES = 16;

    // raw header and footer sizes before alignment
    localparam int HDR_RAW    = 32;
    localparam int FTR_RAW    = 16;
    localparam int FIRST_POOL = 1024 * 1024;

    // field widths of the words on both channels
    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 21;
    localparam int OFFS_W   = 20;
    localparam int STATUS_W = 3;
    localparam int BYTES_W  = 21;
    localparam int CNT_W    = 32;
    localparam int LIVE_W   = 9;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_CFG_BYTES = 3'd0;
    localparam logic [SIZE_W-1:0]  CFG_BYTES_RST = 21'd1048576;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_STATS = 2'd2,
        FUNC_INIT  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_BAD_FREE  = 3'd2,
        ST_ZERO_SIZE = 3'd3,
        ST_TOO_SMALL = 3'd4,
        ST_NOT_INIT  = 3'd5
    } status_t;

endpackage

@@ sv/best_fit_pool_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_pool_allocator_top: best-fit boundary-tag pool allocator
//
// Usage: each s_ word carries one command in s_tuser (allocate, free, reset
// statistics, initialize) with size and offset in s_tdata. Every command
// returns exactly one m_ word: a status code in m_tuser and the allocated
// payload offset plus all statistics in m_tdata.
// The block table lives in a single synchronous RAM walked through its
// address-ordered links, one entry per cycle. In an allocate the split step
// waits for the free-slot scan, which runs beside the walk and can outlast
// a short walk. A free walks the list and then does the neighbor merges.
// One command is in flight at a time; s_tready is high only when idle.
// The result sits in an output register, so the next command is accepted
// while it waits; a stalled m_tready holds the next result in its final
// step until the register drains.
// Reset empties the pool (not initialized) and clears all statistics;
// the first allocate sets up a pool of min(1 MiB, POOL_BYTES) by itself.
// The pool byte count register is written over APB at address 0 and is
// taken by initialize.
// ALIGN_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module best_fit_pool_allocator_top
    import bfpa_pkg::*;
#(
    parameter int POOL_BYTES  = DEF_POOL_BYTES,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // size[20:0], offset[40:21], zero
    input  logic [1:0]           s_tuser,   // func[1:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // payload_offset[19:0], bytes_in_use[40:20], bytes_available[61:41],
    // peak_in_use[82:62], alloc_count[114:83], free_count[146:115],
    // live_blocks[155:147], zero
    output logic [159:0]         m_tdata,
    output logic [2:0]           m_tuser,   // status[2:0]
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // table geometry
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam logic [IW-1:0] NO_LINK = IW'(MAX_BLOCKS);
    // byte quantities
    localparam int SW = $clog2(POOL_BYTES + 1);
    localparam int CW = (SW > 22) ? SW : 22;
    localparam int OW = (SW + 1 > OFFS_W) ? SW + 1 : OFFS_W;
    localparam int HDR = ((HDR_RAW + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int FTR = ((FTR_RAW + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int MIN_BLOCK = HDR + FTR + ALIGN_BYTES;
    localparam int FIRST_BYTES = (FIRST_POOL < POOL_BYTES) ? FIRST_POOL : POOL_BYTES;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [SW-1:0] pay;
        logic          free;
        logic [IW-1:0] next;
        logic [IW-1:0] prev;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_START, S_SRCH, S_DECIDE, S_SLOTW, S_FIXRD, S_FIXWR,
        S_A_WRSL, S_A_WRBEST, S_F_RDNX, S_F_NX, S_F_RDPV, S_F_PV, S_F_WRBLK,
        S_DONE
    } state_t;

    state_t state_reg, ret_reg;

    // command
    func_t              func_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [OFFS_W-1:0]  offset_reg;
    logic [SW-1:0]      setup_bytes_reg;
    status_t            status_reg;
    logic [OFFS_W-1:0]  where_reg;

    // list walk and chosen block
    logic [AW-1:0]      cur_reg;
    logic [IW-1:0]      n_reg;
    logic [IW-1:0]      best_reg;
    entry_t             best_ent_reg;
    logic               split_reg;

    // free-slot scan
    logic [MAX_BLOCKS-1:0] slot_vec_reg;
    logic [IW-1:0]      scan_idx_reg;
    logic               scan_done_reg;
    logic               scan_hit_reg;

    // link repair
    logic [AW-1:0]      fix_idx_reg;
    logic [IW-1:0]      fix_val_reg;

    // statistics
    logic               pool_ready_reg;
    logic [SW-1:0]      stat_in_use_reg;
    logic [SW-1:0]      stat_avail_reg;
    logic [SW-1:0]      stat_peak_reg;
    logic [CNT_W-1:0]   stat_allocs_reg;
    logic [CNT_W-1:0]   stat_frees_reg;
    logic [IW-1:0]      stat_live_reg;

    logic [SIZE_W-1:0]  cfg_bytes_reg;

    // result register
    logic               m_tvalid_reg;
    logic [159:0]       m_tdata_reg;
    logic [2:0]         m_tuser_reg;

    // RAM ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    entry_t             mem_wdata;
    logic [EW-1:0]      mem_rdata;
    entry_t             ent;

    bfpa_entry_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign ent = entry_t'(mem_rdata);

    // ------------------------------------------------------------------
    // datapath terms
    // ------------------------------------------------------------------
    logic [CW-1:0] need;
    logic [CW-1:0] extra;
    logic          split_want;
    logic          alloc_hit;
    logic          free_hit;
    logic          hit;
    logic          exact;
    logic          stop;
    logic [OW-1:0] ent_offs;
    logic [OW-1:0] best_offs;
    logic [SW-1:0] init_bytes;
    logic [SW-1:0] alloc_pay;
    logic [SW-1:0] in_use_sum;
    logic          is_alloc;

    assign is_alloc   = (func_reg == FUNC_ALLOC);
    assign need       = (CW'(size_reg) + CW'(ALIGN_BYTES - 1)) & ~CW'(ALIGN_BYTES - 1);
    assign extra      = CW'(best_ent_reg.pay) - need;
    assign split_want = extra >= CW'(MIN_BLOCK);
    assign exact      = CW'(ent.pay) == need;
    assign alloc_hit  = ent.free && (CW'(ent.pay) >= need) &&
                        ((best_reg == NO_LINK) || (ent.pay < best_ent_reg.pay));
    assign ent_offs   = OW'(ent.start) + OW'(HDR);
    assign best_offs  = OW'(best_ent_reg.start) + OW'(HDR);
    assign free_hit   = ent_offs[OFFS_W-1:0] == offset_reg;
    assign hit        = is_alloc ? alloc_hit : free_hit;
    // end the walk on an exact fit, a found payload, the list end or the bound
    assign stop       = (hit && (!is_alloc || exact)) || (ent.next == NO_LINK) ||
                        (n_reg == IW'(MAX_BLOCKS - 1));
    assign init_bytes = (CW'(cfg_bytes_reg) > CW'(POOL_BYTES)) ? SW'(POOL_BYTES)
                                                               : SW'(cfg_bytes_reg);
    assign alloc_pay  = split_reg ? SW'(need) : best_ent_reg.pay;
    assign in_use_sum = stat_in_use_reg + alloc_pay;

    // ------------------------------------------------------------------
    // RAM access per step
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = fix_idx_reg;
        mem_raddr = cur_reg;
        mem_wdata = best_ent_reg;
        case (state_reg)
            S_SETUP: begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.start = '0;
                mem_wdata.pay   = setup_bytes_reg - SW'(HDR + FTR);
                mem_wdata.free  = 1'b1;
                mem_wdata.next  = NO_LINK;
                mem_wdata.prev  = NO_LINK;
            end
            S_START: begin
                mem_raddr = '0;
            end
            S_SRCH: begin
                mem_raddr = ent.next[AW-1:0];
            end
            S_FIXRD: begin
                mem_raddr = fix_idx_reg;
            end
            S_FIXWR: begin
                mem_we         = 1'b1;
                mem_wdata      = ent;
                mem_wdata.prev = fix_val_reg;
            end
            S_A_WRSL: begin
                mem_we          = 1'b1;
                mem_waddr       = scan_idx_reg[AW-1:0];
                mem_wdata.start = SW'(CW'(best_ent_reg.start) + CW'(HDR + FTR) + need);
                mem_wdata.pay   = SW'(extra - CW'(HDR + FTR));
                mem_wdata.free  = 1'b1;
                mem_wdata.next  = best_ent_reg.next;
                mem_wdata.prev  = best_reg;
            end
            S_A_WRBEST: begin
                mem_we         = 1'b1;
                mem_waddr      = best_reg[AW-1:0];
                mem_wdata.free = 1'b0;
                mem_wdata.pay  = alloc_pay;
                if (split_reg) begin
                    mem_wdata.next = scan_idx_reg;
                end
            end
            S_F_RDNX: begin
                mem_raddr = best_ent_reg.next[AW-1:0];
            end
            S_F_RDPV: begin
                mem_raddr = best_ent_reg.prev[AW-1:0];
            end
            S_F_PV: begin
                mem_we        = ent.free;
                mem_waddr     = best_ent_reg.prev[AW-1:0];
                mem_wdata     = ent;
                mem_wdata.pay = ent.pay + SW'(HDR + FTR) + best_ent_reg.pay;
                mem_wdata.next = best_ent_reg.next;
            end
            S_F_WRBLK: begin
                mem_we         = 1'b1;
                mem_waddr      = best_reg[AW-1:0];
                mem_wdata.free = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            pool_ready_reg  <= 1'b0;
            slot_vec_reg    <= '0;
            stat_in_use_reg <= '0;
            stat_avail_reg  <= '0;
            stat_peak_reg   <= '0;
            stat_allocs_reg <= '0;
            stat_frees_reg  <= '0;
            stat_live_reg   <= '0;
            cfg_bytes_reg   <= CFG_BYTES_RST;
            m_tvalid_reg    <= 1'b0;
            scan_done_reg   <= 1'b1;
            scan_hit_reg    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && (paddr == REG_CFG_BYTES)) begin
                cfg_bytes_reg <= pwdata[SIZE_W-1:0];
            end

            // drop the result once taken, unless a new one is loaded now
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            // free-slot scan runs beside the list walk of an allocate
            if (!scan_done_reg) begin
                if (scan_idx_reg == NO_LINK) begin
                    scan_done_reg <= 1'b1;
                end else if (!slot_vec_reg[scan_idx_reg[AW-1:0]]) begin
                    scan_done_reg <= 1'b1;
                    scan_hit_reg  <= 1'b1;
                end else begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        func_reg   <= func_t'(s_tuser[FUNC_W-1:0]);
                        size_reg   <= s_tdata[SIZE_W-1:0];
                        offset_reg <= s_tdata[SIZE_W+OFFS_W-1:SIZE_W];
                        where_reg  <= '0;
                        status_reg <= ST_OK;
                        case (func_t'(s_tuser[FUNC_W-1:0]))
                            FUNC_ALLOC: begin
                                setup_bytes_reg <= SW'(FIRST_BYTES);
                                if (s_tdata[SIZE_W-1:0] == '0) begin
                                    status_reg <= ST_ZERO_SIZE;
                                    state_reg  <= S_DONE;
                                end else if (!pool_ready_reg) begin
                                    state_reg <= S_SETUP;
                                end else begin
                                    state_reg <= S_START;
                                end
                            end
                            FUNC_FREE: begin
                                if (!pool_ready_reg) begin
                                    status_reg <= ST_NOT_INIT;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg <= S_START;
                                end
                            end
                            FUNC_STATS: begin
                                stat_peak_reg   <= stat_in_use_reg;
                                stat_allocs_reg <= CNT_W'(stat_live_reg);
                                stat_frees_reg  <= '0;
                                state_reg       <= S_DONE;
                            end
                            default: begin
                                setup_bytes_reg <= init_bytes;
                                if (init_bytes < SW'(2 * MIN_BLOCK)) begin
                                    status_reg <= ST_TOO_SMALL;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg <= S_SETUP;
                                end
                            end
                        endcase
                    end
                end

                S_SETUP: begin
                    // entry 0 is written by the RAM port this cycle
                    slot_vec_reg    <= MAX_BLOCKS'(1);
                    pool_ready_reg  <= 1'b1;
                    stat_in_use_reg <= '0;
                    stat_avail_reg  <= setup_bytes_reg - SW'(HDR + FTR);
                    stat_peak_reg   <= '0;
                    stat_allocs_reg <= '0;
                    stat_frees_reg  <= '0;
                    stat_live_reg   <= '0;
                    state_reg       <= is_alloc ? S_START : S_DONE;
                end

                S_START: begin
                    cur_reg       <= '0;
                    n_reg         <= '0;
                    best_reg      <= NO_LINK;
                    scan_idx_reg  <= '0;
                    scan_done_reg <= !is_alloc;
                    scan_hit_reg  <= 1'b0;
                    state_reg     <= S_SRCH;
                end

                S_SRCH: begin
                    if (hit) begin
                        best_reg     <= IW'(cur_reg);
                        best_ent_reg <= ent;
                    end
                    if (stop) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        cur_reg <= ent.next[AW-1:0];
                        n_reg   <= n_reg + 1'b1;
                    end
                end

                S_DECIDE: begin
                    if (is_alloc) begin
                        if (best_reg == NO_LINK) begin
                            status_reg <= ST_NO_MEM;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_SLOTW;
                        end
                    end else if ((best_reg == NO_LINK) || best_ent_reg.free) begin
                        status_reg <= ST_BAD_FREE;
                        state_reg  <= S_DONE;
                    end else begin
                        stat_in_use_reg <= (stat_in_use_reg >= best_ent_reg.pay) ?
                                           stat_in_use_reg - best_ent_reg.pay : '0;
                        stat_avail_reg  <= stat_avail_reg + best_ent_reg.pay;
                        stat_frees_reg  <= stat_frees_reg + 1'b1;
                        if (stat_live_reg != '0) begin
                            stat_live_reg <= stat_live_reg - 1'b1;
                        end
                        state_reg <= S_F_RDNX;
                    end
                end

                S_SLOTW: begin
                    if (scan_done_reg) begin
                        split_reg <= split_want && scan_hit_reg;
                        if (split_want && scan_hit_reg) begin
                            if (best_ent_reg.next != NO_LINK) begin
                                fix_idx_reg <= best_ent_reg.next[AW-1:0];
                                fix_val_reg <= scan_idx_reg;
                                ret_reg     <= S_A_WRSL;
                                state_reg   <= S_FIXRD;
                            end else begin
                                state_reg <= S_A_WRSL;
                            end
                        end else begin
                            state_reg <= S_A_WRBEST;
                        end
                    end
                end

                S_FIXRD: begin
                    state_reg <= S_FIXWR;
                end

                S_FIXWR: begin
                    state_reg <= ret_reg;
                end

                S_A_WRSL: begin
                    slot_vec_reg[scan_idx_reg[AW-1:0]] <= 1'b1;
                    state_reg <= S_A_WRBEST;
                end

                S_A_WRBEST: begin
                    stat_in_use_reg <= in_use_sum;
                    stat_avail_reg  <= (stat_avail_reg >= alloc_pay) ?
                                       stat_avail_reg - alloc_pay : '0;
                    if (in_use_sum > stat_peak_reg) begin
                        stat_peak_reg <= in_use_sum;
                    end
                    stat_allocs_reg <= stat_allocs_reg + 1'b1;
                    stat_live_reg   <= stat_live_reg + 1'b1;
                    where_reg       <= best_offs[OFFS_W-1:0];
                    state_reg       <= S_DONE;
                end

                S_F_RDNX: begin
                    state_reg <= (best_ent_reg.next != NO_LINK) ? S_F_NX : S_F_RDPV;
                end

                S_F_NX: begin
                    // absorb a free successor
                    if (ent.free) begin
                        best_ent_reg.pay  <= best_ent_reg.pay + SW'(HDR + FTR) + ent.pay;
                        best_ent_reg.next <= ent.next;
                        slot_vec_reg[best_ent_reg.next[AW-1:0]] <= 1'b0;
                        if (ent.next != NO_LINK) begin
                            fix_idx_reg <= ent.next[AW-1:0];
                            fix_val_reg <= best_reg;
                            ret_reg     <= S_F_RDPV;
                            state_reg   <= S_FIXRD;
                        end else begin
                            state_reg <= S_F_RDPV;
                        end
                    end else begin
                        state_reg <= S_F_RDPV;
                    end
                end

                S_F_RDPV: begin
                    state_reg <= (best_ent_reg.prev != NO_LINK) ? S_F_PV : S_F_WRBLK;
                end

                S_F_PV: begin
                    // fold into a free predecessor, else mark the block free
                    if (ent.free) begin
                        slot_vec_reg[best_reg[AW-1:0]] <= 1'b0;
                        if (best_ent_reg.next != NO_LINK) begin
                            fix_idx_reg <= best_ent_reg.next[AW-1:0];
                            fix_val_reg <= best_ent_reg.prev;
                            ret_reg     <= S_DONE;
                            state_reg   <= S_FIXRD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        state_reg <= S_F_WRBLK;
                    end
                end

                S_F_WRBLK: begin
                    state_reg <= S_DONE;
                end

                S_DONE: begin
                    // hold until the result register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {4'd0,
                                         LIVE_W'(stat_live_reg),
                                         stat_frees_reg,
                                         stat_allocs_reg,
                                         BYTES_W'(stat_peak_reg),
                                         BYTES_W'(stat_avail_reg),
                                         BYTES_W'(stat_in_use_reg),
                                         where_reg};
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_CFG_BYTES) ? PDATA_W'(cfg_bytes_reg) : '0;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_live_reg <= IW'(MAX_BLOCKS))
        else $error("live block count above table size");

    a_in_use_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(stat_in_use_reg) <= CW'(POOL_BYTES))
        else $error("bytes in use above pool size");

    a_head_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        pool_ready_reg |-> slot_vec_reg[0])
        else $error("head slot released on a ready pool");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH) |-> (n_reg < IW'(MAX_BLOCKS)))
        else $error("list walk ran past the table bound");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the completion step");

endmodule

@@ sv/bfpa_entry_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_entry_ram: block table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfpa_entry_ram
    import bfpa_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_BLOCKS,
    parameter int WIDTH = 64,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ dv/best_fit_pool_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_pool_allocator_top_tb: self-checking bench for the pool allocator
// Drives commands on the s_ stream and the pool byte count over APB, predicts
// each result word with a behavioral copy of the block table and statistics,
// and compares every m_ word field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module best_fit_pool_allocator_top_tb;
    import bfpa_pkg::*;

    localparam int TBL      = DEF_MAX_BLOCKS;
    localparam int HDR      = 32;
    localparam int FTR      = 16;
    localparam int MINBLK   = HDR + FTR + 16;
    localparam int LIMIT    = 3000000;

    typedef struct {
        status_t          status;
        logic [19:0]      where;
        logic [20:0]      in_use;
        logic [20:0]      avail;
        logic [20:0]      peak;
        logic [31:0]      allocs;
        logic [31:0]      frees;
        logic [8:0]       live;
    } alloc_result_t;

    // Behavioral copy of the allocator plus the queue of pending results.
    class alloc_scoreboard;
        int unsigned   blk_start[TBL], blk_payload[TBL], blk_next[TBL], blk_prev[TBL];
        bit            blk_free[TBL], slot_used[TBL];
        bit            ready;
        int unsigned   in_use, avail, peak, allocs, frees, live;
        int unsigned   pool_cfg;
        alloc_result_t expected_q[$];
        int unsigned   live_offsets[$];
        int unsigned   stale_offsets[$];
        int            errors;
        int            n_status[8];
        int            n_split, n_full;

        function new();
            pool_cfg = 1048576;
        endfunction

        function int unsigned rnd16(int unsigned x);
            return (x + 15) / 16 * 16;
        endfunction

        function bit setup_pool(int unsigned bytes);
            if (bytes > DEF_POOL_BYTES) bytes = DEF_POOL_BYTES;
            if (bytes < 2 * MINBLK) return 0;
            foreach (slot_used[i]) slot_used[i] = 0;
            slot_used[0]   = 1;
            blk_start[0]   = 0;
            blk_payload[0] = bytes - HDR - FTR;
            blk_free[0]    = 1;
            blk_next[0]    = TBL;
            blk_prev[0]    = TBL;
            ready  = 1;
            in_use = 0;
            avail  = blk_payload[0];
            peak   = 0;
            allocs = 0;
            frees  = 0;
            live   = 0;
            live_offsets.delete();
            stale_offsets.delete();
            return 1;
        endfunction

        function status_t allocate(int unsigned size, output int unsigned where);
            int unsigned need, cur, best, best_pay, extra, sl, nx;
            where = 0;
            if (size == 0) return ST_ZERO_SIZE;
            if (!ready && !setup_pool(FIRST_POOL)) return ST_TOO_SMALL;
            need = rnd16(size);
            best = TBL;
            best_pay = 0;
            cur = 0;
            for (int n = 0; n < TBL && cur < TBL; n++) begin
                if (blk_free[cur] && blk_payload[cur] >= need &&
                    (best == TBL || blk_payload[cur] < best_pay)) begin
                    best = cur;
                    best_pay = blk_payload[cur];
                    if (best_pay == need) break;
                end
                cur = blk_next[cur];
            end
            if (best == TBL) return ST_NO_MEM;
            extra = blk_payload[best] - need;
            if (extra >= MINBLK) begin
                sl = TBL;
                for (int i = 0; i < TBL; i++)
                    if (!slot_used[i]) begin
                        sl = i;
                        break;
                    end
                if (sl < TBL) begin
                    n_split++;
                    slot_used[sl]   = 1;
                    blk_payload[best] = need;
                    blk_start[sl]   = blk_start[best] + HDR + need + FTR;
                    blk_payload[sl] = extra - HDR - FTR;
                    blk_free[sl]    = 1;
                    blk_prev[sl]    = best;
                    nx = blk_next[best];
                    blk_next[sl]    = nx;
                    if (nx < TBL) blk_prev[nx] = sl;
                    blk_next[best]  = sl;
                end else begin
                    n_full++;
                end
            end
            blk_free[best] = 0;
            in_use += blk_payload[best];
            avail = (avail >= blk_payload[best]) ? avail - blk_payload[best] : 0;
            if (in_use > peak) peak = in_use;
            allocs++;
            live++;
            where = blk_start[best] + HDR;
            live_offsets.push_back(where & 20'hFFFFF);
            return ST_OK;
        endfunction

        function status_t release_block(int unsigned offs);
            int unsigned cur, blk, nx, pv;
            if (!ready) return ST_NOT_INIT;
            cur = 0;
            blk = TBL;
            for (int n = 0; n < TBL && cur < TBL; n++) begin
                if (((blk_start[cur] + HDR) & 20'hFFFFF) == offs) begin
                    blk = cur;
                    break;
                end
                cur = blk_next[cur];
            end
            if (blk == TBL || blk_free[blk]) return ST_BAD_FREE;
            blk_free[blk] = 1;
            in_use = (in_use >= blk_payload[blk]) ? in_use - blk_payload[blk] : 0;
            avail += blk_payload[blk];
            frees++;
            if (live > 0) live--;
            foreach (live_offsets[i])
                if (live_offsets[i] == offs) begin
                    live_offsets.delete(i);
                    break;
                end
            stale_offsets.push_back(offs);
            nx = blk_next[blk];
            if (nx < TBL && blk_free[nx]) begin
                blk_payload[blk] += HDR + blk_payload[nx] + FTR;
                blk_next[blk] = blk_next[nx];
                if (blk_next[nx] < TBL) blk_prev[blk_next[nx]] = blk;
                slot_used[nx] = 0;
            end
            pv = blk_prev[blk];
            if (pv < TBL && blk_free[pv]) begin
                blk_payload[pv] += HDR + blk_payload[blk] + FTR;
                blk_next[pv] = blk_next[blk];
                if (blk_next[blk] < TBL) blk_prev[blk_next[blk]] = pv;
                slot_used[blk] = 0;
            end
            return ST_OK;
        endfunction

        // Note an accepted command word and queue its predicted result.
        function void note_command(func_t f, int unsigned size, int unsigned offs);
            alloc_result_t r;
            int unsigned where;
            where = 0;
            case (f)
                FUNC_ALLOC: r.status = allocate(size, where);
                FUNC_FREE:  r.status = release_block(offs);
                FUNC_STATS: begin
                    peak   = in_use;
                    allocs = live;
                    frees  = 0;
                    r.status = ST_OK;
                end
                default:    r.status = setup_pool(pool_cfg) ? ST_OK : ST_TOO_SMALL;
            endcase
            n_status[r.status]++;
            r.where  = where[19:0];
            r.in_use = in_use[20:0];
            r.avail  = avail[20:0];
            r.peak   = peak[20:0];
            r.allocs = allocs;
            r.frees  = frees;
            r.live   = live[8:0];
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] exp);
            if (got !== exp) report($sformatf("%s got %0h expected %0h", name, got, exp));
        endtask

        // Check one result word against the oldest expectation.
        task check_result(logic [2:0] user, logic [159:0] data);
            alloc_result_t e;
            if (expected_q.size() == 0) begin
                report("result word with no command pending");
                return;
            end
            e = expected_q.pop_front();
            cmp("status",          32'(user),           32'(e.status));
            cmp("payload_offset",  32'(data[19:0]),     32'(e.where));
            cmp("bytes_in_use",    32'(data[40:20]),    32'(e.in_use));
            cmp("bytes_available", 32'(data[61:41]),    32'(e.avail));
            cmp("peak_in_use",     32'(data[82:62]),    32'(e.peak));
            cmp("alloc_count",     data[114:83],        e.allocs);
            cmp("free_count",      data[146:115],       e.frees);
            cmp("live_blocks",     32'(data[155:147]),  32'(e.live));
            cmp("tdata pad",       32'(data[159:156]),  32'd0);
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;   // size[20:0], offset[40:21], zero
    logic [1:0]          s_tuser;   // func[1:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [159:0]        m_tdata;   // offset, in_use, avail, peak, allocs, frees, live
    logic [2:0]          m_tuser;   // status[2:0]
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    alloc_scoreboard sb;
    int              cycles;
    int              hold_req;
    int              hold_cnt;
    bit              no_idle;

    best_fit_pool_allocator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Watchdog: end the run if the block stops answering.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Monitor: check result words first, then note the accepted command word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
        if (aresetn && s_tvalid && s_tready)
            sb.note_command(func_t'(s_tuser), 32'(s_tdata[20:0]), 32'(s_tdata[40:21]));
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            m_tready = 1'b0;
            hold_cnt--;
        end else begin
            m_tready = no_idle || ($urandom_range(99) >= 29);
        end
    end

    // Offer one command word; return at the falling edge after it is taken.
    task send_cmd(func_t f, int unsigned size, int unsigned offs);
        logic rdy;
        if (!no_idle && $urandom_range(99) < 29) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = {7'd0, offs[19:0], size[20:0]};
        // s_tready only moves at rising edges, so its value here decides the next edge
        do begin
            rdy = s_tready;
            @(posedge aclk);
            @(negedge aclk);
        end while (!rdy);
        s_tvalid = 1'b0;
    endtask

    // Drain every pending result before touching the register.
    task wait_idle();
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task apb_write(logic [31:0] value);
        wait_idle();
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = REG_CFG_BYTES;
        pwdata  = value;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(negedge aclk); while (!pready);
        sb.pool_cfg = value & 32'h1FFFFF;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        // read it back
        psel    = 1'b1;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        sb.cmp("prdata", prdata, sb.pool_cfg);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)  return 0;
        if (r < 70) return $urandom_range(1, 256);
        if (r < 93) return $urandom_range(257, 8192);
        return $urandom_range(0, 21'h1FFFFF);
    endfunction

    function int unsigned pick_offset();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80 && sb.live_offsets.size() > 0)
            return sb.live_offsets[$urandom_range(sb.live_offsets.size() - 1)];
        if (r < 90 && sb.stale_offsets.size() > 0)
            return sb.stale_offsets[$urandom_range(sb.stale_offsets.size() - 1)];
        return $urandom_range(0, 20'hFFFFF);
    endfunction

    // One random command: mostly alloc/free traffic, rare stats and init.
    task random_cmd();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)      send_cmd(FUNC_ALLOC, pick_size(), $urandom_range(0, 20'hFFFFF));
        else if (r < 93) send_cmd(FUNC_FREE, $urandom_range(0, 21'h1FFFFF), pick_offset());
        else if (r < 98) send_cmd(FUNC_STATS, $urandom_range(0, 21'h1FFFFF),
                                  $urandom_range(0, 20'hFFFFF));
        else             send_cmd(FUNC_INIT, $urandom_range(0, 21'h1FFFFF),
                                  $urandom_range(0, 20'hFFFFF));
    endtask

    initial begin
        int unsigned first_off, second_off;
        sb       = new();
        cycles   = 0;
        hold_req = 0;
        hold_cnt = 0;
        no_idle  = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_ALLOC;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = REG_CFG_BYTES;
        pwdata   = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: behavior before the pool exists, then the first allocation.
        send_cmd(FUNC_FREE, 0, 32);                 // free before init
        send_cmd(FUNC_STATS, 0, 0);                 // stats before init
        send_cmd(FUNC_ALLOC, 0, 0);                 // zero size, no auto init
        send_cmd(FUNC_ALLOC, 1, 0);                 // first alloc sets up the pool
        send_cmd(FUNC_ALLOC, 16, 0);
        wait_idle();
        first_off  = sb.live_offsets[0];
        second_off = sb.live_offsets[1];
        send_cmd(FUNC_FREE, 0, first_off);
        send_cmd(FUNC_FREE, 0, first_off);          // double free
        send_cmd(FUNC_FREE, 0, 20'hFFFFF);          // offset matches nothing
        send_cmd(FUNC_ALLOC, 21'h100000, 0);        // no fit
        send_cmd(FUNC_FREE, 0, second_off);         // merge on both sides
        send_cmd(FUNC_STATS, 0, 0);

        // Directed: smallest pools and the exact fit
        apb_write(32'd0);
        send_cmd(FUNC_INIT, 0, 0);                  // too small
        apb_write(2 * MINBLK - 1);
        send_cmd(FUNC_INIT, 0, 0);                  // too small by one
        apb_write(2 * MINBLK);
        send_cmd(FUNC_INIT, 0, 0);
        send_cmd(FUNC_ALLOC, 80, 0);                // exact fit of the whole pool
        send_cmd(FUNC_ALLOC, 16, 0);                // nothing left
        send_cmd(FUNC_FREE, 0, HDR);
        send_cmd(FUNC_ALLOC, 16, 0);                // split leaves one minimum block
        send_cmd(FUNC_ALLOC, 16, 0);                // takes the split-off rest
        apb_write(32'hFFFF_FFFF);                   // saturates at the pool limit
        send_cmd(FUNC_INIT, 0, 0);
        send_cmd(FUNC_ALLOC, 21'h1FFFFF, 0);

        // Random phase on a full pool: long receiver hold-off mid-way.
        apb_write(32'd1048576);
        send_cmd(FUNC_INIT, 0, 0);
        for (int i = 0; i < 150; i++) begin
            if (i == 80) hold_req = 400;            // fill up and stall the input
            if (i == 140) wait_idle();              // drain before going on
            random_cmd();
        end

        // Random phase on a small pool: many out-of-memory answers.
        apb_write($urandom_range(4096, 65536));
        send_cmd(FUNC_INIT, 0, 0);
        for (int i = 0; i < 110; i++) random_cmd();

        // Fill the block table with no idling on either side, then free.
        apb_write(32'd1048576);
        send_cmd(FUNC_INIT, 0, 0);
        no_idle = 1;
        for (int i = 0; i < 300; i++) send_cmd(FUNC_ALLOC, $urandom_range(1, 48), 0);
        no_idle = 0;
        for (int i = 0; i < 60; i++) random_cmd();

        wait_idle();
        repeat (300) @(negedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report("results still pending at end");
        $display("covered: %0d ok, %0d out of memory, %0d bad free, %0d zero size,",
                 sb.n_status[ST_OK], sb.n_status[ST_NO_MEM], sb.n_status[ST_BAD_FREE],
                 sb.n_status[ST_ZERO_SIZE]);
        $display("  %0d too small, %0d not init, %0d splits, %0d table-full allocs",
                 sb.n_status[ST_TOO_SMALL], sb.n_status[ST_NOT_INIT], sb.n_split,
                 sb.n_full);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
sv/bfpa_pkg.sv
sv/bfpa_entry_ram.sv
sv/best_fit_pool_allocator_top.sv
dv/best_fit_pool_allocator_top_tb.sv
